// File: rtl/qdec_pkg.sv
package qdec_pkg;

	// item actions
	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_INIT   = 2'd3
	} action_t;

	// per-channel decoder state
	typedef struct packed {
		logic        [1:0]  last_phase;
		logic signed [31:0] position;
		logic signed [1:0]  velocity;
		logic        [31:0] err_total;
	} chan_state_t;

	// step for {old phase, new phase}, phase is {a, b}
	localparam logic signed [1:0] STEP_LUT [0:15] = '{
		2'sb00, 2'sb11, 2'sb01, 2'sb00,
		2'sb01, 2'sb00, 2'sb00, 2'sb11,
		2'sb11, 2'sb00, 2'sb00, 2'sb01,
		2'sb00, 2'sb01, 2'sb11, 2'sb00
	};

endpackage

// File: rtl/qdec_step.sv
module qdec_step (
	input  qdec_pkg::chan_state_t cur,
	input  qdec_pkg::action_t     action,
	input  logic [1:0]            phase,
	output qdec_pkg::chan_state_t nxt
);
	import qdec_pkg::*;

	logic signed [1:0] step;

	assign step = STEP_LUT[{cur.last_phase, phase}];

	// apply one action to the channel state
	always_comb begin
		nxt = cur;
		case (action)
			ACT_SAMPLE: begin
				if (step != 2'sb00) begin
					if (step > 2'sb00) begin
						nxt.position = cur.position + 32'sd1;
					end else begin
						nxt.position = cur.position - 32'sd1;
					end
					nxt.velocity = step;
				end else if (cur.last_phase != phase) begin
					// both phases flipped at once
					nxt.err_total = cur.err_total + 32'd1;
				end
				nxt.last_phase = phase;
			end
			ACT_CLEAR: begin
				nxt.position  = '0;
				nxt.velocity  = '0;
				nxt.err_total = '0;
			end
			ACT_INIT: begin
				nxt.last_phase = phase;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// File: rtl/qdec_state.sv
module qdec_state #(
	parameter int CHANNELS = 4,
	parameter int IDX_W    = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_idx,
	input  qdec_pkg::chan_state_t wr_data,
	input  logic [IDX_W-1:0]      rd_idx,
	output qdec_pkg::chan_state_t rd_data
);
	import qdec_pkg::*;

	chan_state_t state_q [CHANNELS];

	// channel state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else if (wr_en) begin
			state_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = state_q[rd_idx];

endmodule

// File: rtl/multi_channel_quadrature_decoder.sv
// Multi-channel x4 quadrature decoder.
// Input stream (s_*): one beat per action on one encoder channel. tdata holds
// action, channel, phase_a, phase_b. Actions: sample phases, read, clear the
// counts, init (capture the phase without counting).
// Output stream (m_*): exactly one beat per input beat, in order, carrying the
// channel's position, velocity and error count as they stand after the action.
// A channel index at or above CHANNELS changes nothing and answers zeros.
// A beat passes the input register, then the result register, before it is
// offered on m_*. Throughput: one beat per cycle while m_tready stays high;
// the state update of one beat is written at the edge at which that beat leaves
// the input register, so the next beat reads it and beats to the same channel
// follow back to back.
// Reset clears all channel state and empties both registers.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat; s_tready then drops until m_tready returns.
module multi_channel_quadrature_decoder #(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // action[1:0], channel[3:2], phase_a[4], phase_b[5], rest unused
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // position[31:0], velocity[33:32], err_total[65:34], zero
);
	import qdec_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic              valid_s1;
	action_t           action_s1;
	logic [1:0]        channel_s1;
	logic [1:0]        phase_s1;
	logic              in_range_s1;
	logic              advance;
	logic [IDX_W-1:0]  idx_s1;
	chan_state_t       cur_state;
	chan_state_t       nxt_state;

	logic              out_valid_q;
	logic signed [31:0] position_q;
	logic signed [1:0]  velocity_q;
	logic [31:0]       error_q;

	// handshake: stage 1 moves on when the result register is empty or is being read
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1   <= action_t'(s_tdata[1:0]);
			channel_s1  <= s_tdata[3:2];
			phase_s1    <= {s_tdata[4], s_tdata[5]};
			in_range_s1 <= (32'(s_tdata[3:2]) < CHANNELS);
		end
	end

	assign idx_s1 = IDX_W'(channel_s1);

	qdec_state #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (advance && in_range_s1),
		.wr_idx  (idx_s1),
		.wr_data (nxt_state),
		.rd_idx  (idx_s1),
		.rd_data (cur_state)
	);

	qdec_step u_step (
		.cur    (cur_state),
		.action (action_s1),
		.phase  (phase_s1),
		.nxt    (nxt_state)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (in_range_s1) begin
				position_q <= nxt_state.position;
				velocity_q <= nxt_state.velocity;
				error_q    <= nxt_state.err_total;
			end else begin
				position_q <= '0;
				velocity_q <= '0;
				error_q    <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, error_q, velocity_q, position_q};

`ifndef SYNTHESIS
	// a beat leaving stage 1 is offered in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) advance |=> m_tvalid)
		else $error("result beat missing after stage 1 advance");

	// an empty result register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n) !m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// channel out of range answers zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !in_range_s1 |=> m_tdata == 72'd0)
		else $error("out-of-range channel gave nonzero result");

	// clear leaves zero counts
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range_s1 && action_s1 == ACT_CLEAR |=> m_tdata[65:0] == 66'd0)
		else $error("clear did not zero the counts");
`endif

endmodule
